// ----- rtl/epc_pkg.sv -----
// shared constants, counter map and latency binning for the profile counters
package epc_pkg;

  localparam int NUM_COUNTERS     = 46;
  localparam int COUNTER_BITS_DEF = 32;
  localparam int LATENCY_BINS     = 9;
  localparam int CNT_AW           = $clog2(NUM_COUNTERS);

  // operation codes carried on the input channel
  localparam logic [2:0] OP_READ_DONE = 3'd0;
  localparam logic [2:0] OP_SEEK_DONE = 3'd1;
  localparam logic [2:0] OP_TEX_BEGIN = 3'd2;
  localparam logic [2:0] OP_TEX_END   = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_READ_CNT  = 3'd5;

  // counter map
  localparam logic [CNT_AW-1:0] C_RD_CALLS  = CNT_AW'(0);
  localparam logic [CNT_AW-1:0] C_RD_REQ    = CNT_AW'(1);
  localparam logic [CNT_AW-1:0] C_RD_BYTES  = CNT_AW'(2);
  localparam logic [CNT_AW-1:0] C_RD_TIME   = CNT_AW'(3);
  localparam logic [CNT_AW-1:0] C_RD_ERR    = CNT_AW'(4);
  localparam logic [CNT_AW-1:0] C_RD_MAX    = CNT_AW'(5);
  localparam logic [CNT_AW-1:0] C_RD_LE4K   = CNT_AW'(6);
  localparam logic [CNT_AW-1:0] C_RD_LE64K  = CNT_AW'(7);
  localparam logic [CNT_AW-1:0] C_RD_GT64K  = CNT_AW'(8);
  localparam logic [CNT_AW-1:0] C_RD_LAT    = CNT_AW'(9);
  localparam logic [CNT_AW-1:0] C_SK_CALLS  = CNT_AW'(18);
  localparam logic [CNT_AW-1:0] C_SK_32     = CNT_AW'(19);
  localparam logic [CNT_AW-1:0] C_SK_64     = CNT_AW'(20);
  localparam logic [CNT_AW-1:0] C_SK_SET    = CNT_AW'(21);
  localparam logic [CNT_AW-1:0] C_SK_CUR    = CNT_AW'(22);
  localparam logic [CNT_AW-1:0] C_SK_END    = CNT_AW'(23);
  localparam logic [CNT_AW-1:0] C_SK_OTHER  = CNT_AW'(24);
  localparam logic [CNT_AW-1:0] C_SK_TIME   = CNT_AW'(25);
  localparam logic [CNT_AW-1:0] C_SK_ERR    = CNT_AW'(26);
  localparam logic [CNT_AW-1:0] C_SK_LAT    = CNT_AW'(27);
  localparam logic [CNT_AW-1:0] C_TX_IMG    = CNT_AW'(36);
  localparam logic [CNT_AW-1:0] C_TX_SUB    = CNT_AW'(37);
  localparam logic [CNT_AW-1:0] C_TX_PIX    = CNT_AW'(38);
  localparam logic [CNT_AW-1:0] C_TX_TIME   = CNT_AW'(39);
  localparam logic [CNT_AW-1:0] C_TX_MAXPIX = CNT_AW'(40);
  localparam logic [CNT_AW-1:0] C_TX_INFL   = CNT_AW'(41);
  localparam logic [CNT_AW-1:0] C_TX_KIND   = CNT_AW'(42);
  localparam logic [CNT_AW-1:0] C_TX_W      = CNT_AW'(43);
  localparam logic [CNT_AW-1:0] C_TX_H      = CNT_AW'(44);
  localparam logic [CNT_AW-1:0] C_TX_BEGIN  = CNT_AW'(45);

  // seek origin codes
  localparam logic [7:0] ORG_SET = 8'd0;
  localparam logic [7:0] ORG_CUR = 8'd1;
  localparam logic [7:0] ORG_END = 8'd2;

  // read size class limits
  localparam logic [31:0] SIZE_4K  = 32'd4096;
  localparam logic [31:0] SIZE_64K = 32'd65536;

  // latency bin upper bounds, exclusive
  localparam logic [31:0] LAT_B0 = 32'd16;
  localparam logic [31:0] LAT_B1 = 32'd64;
  localparam logic [31:0] LAT_B2 = 32'd256;
  localparam logic [31:0] LAT_B3 = 32'd1024;
  localparam logic [31:0] LAT_B4 = 32'd2048;
  localparam logic [31:0] LAT_B5 = 32'd4096;
  localparam logic [31:0] LAT_B6 = 32'd8192;
  localparam logic [31:0] LAT_B7 = 32'd16384;

  function automatic logic [3:0] lat_bin(logic [31:0] t);
    logic [3:0] bin;
    if (t < LAT_B0)      bin = 4'd0;
    else if (t < LAT_B1) bin = 4'd1;
    else if (t < LAT_B2) bin = 4'd2;
    else if (t < LAT_B3) bin = 4'd3;
    else if (t < LAT_B4) bin = 4'd4;
    else if (t < LAT_B5) bin = 4'd5;
    else if (t < LAT_B6) bin = 4'd6;
    else if (t < LAT_B7) bin = 4'd7;
    else                 bin = 4'(LATENCY_BINS - 1);
    return bin;
  endfunction

endpackage

// ----- rtl/epc_in_if.sv -----
// event channel interface: valid, ready and the event beat
interface epc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [31:0]        read_size;
  logic signed [31:0] read_outcome;
  logic [7:0]         seek_origin;
  logic               seek_failed;
  logic               seek_api32;
  logic [31:0]        elapsed_us;
  logic               texture_sub;
  logic signed [31:0] texture_width;
  logic signed [31:0] texture_height;
  logic [31:0]        now_us;
  logic [5:0]         counter_index;

  modport source (
    output valid, operation, read_size, read_outcome, seek_origin, seek_failed,
           seek_api32, elapsed_us, texture_sub, texture_width, texture_height,
           now_us, counter_index,
    input  ready
  );
  modport sink (
    input  valid, operation, read_size, read_outcome, seek_origin, seek_failed,
           seek_api32, elapsed_us, texture_sub, texture_width, texture_height,
           now_us, counter_index,
    output ready
  );
endinterface

// ----- rtl/epc_out_if.sv -----
// result channel interface: valid, ready and the counter readout beat
interface epc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] counter_value;
  logic        index_invalid;

  modport source (output valid, counter_value, index_invalid, input ready);
  modport sink   (input valid, counter_value, index_invalid, output ready);
endinterface

// ----- rtl/epc_ram.sv -----
// generic single write port, single read port ram with registered read
module epc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 46
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/io_event_profile_counters_core.sv -----
// event-driven i/o and texture profile counters around one counter ram
// a read counter beat passes the event register, modify stage and result register
// one counter update a cycle unless a held readout stalls; steps: read done 7, seek 6,
//   texture begin 8, texture end 3, clear / read counter / ignored events 1, back to back
// reset: synchronous active low; disables profiling and drops all 46 entry valid
//   bits at once, so every counter reads zero with no clearing pass
module io_event_profile_counters_core import epc_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  epc_in_if.sink     in_bus,
  epc_out_if.source  out_bus,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  localparam logic [COUNTER_BITS-1:0] CMAX   = '1;
  localparam logic [63:0]             CMAX64 = 64'(CMAX);

  // one read-modify-write step on one counter, or a clear of all counters
  typedef enum logic [3:0] {
    U_NOP,    // slot with no effect
    U_BUMP,   // saturating add
    U_MAX,    // raise to maximum
    U_SET,    // plain store
    U_INFL,   // test in-flight flag and drop it
    U_BEGIN,  // capture stored begin time
    U_TIME,   // add wrapped time since begin when in flight
    U_CLEAR,  // zero all counters
    U_READ    // counter readout
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t         kind;
    logic [CNT_AW-1:0] addr;
    logic [31:0]       amount;
    logic              bad_idx;
  } uop_t;

  function automatic logic [COUNTER_BITS-1:0] clamp_amt(logic [31:0] a);
    logic [63:0] a64;
    a64 = 64'(a);
    return (a64 > CMAX64) ? CMAX : a64[COUNTER_BITS-1:0];
  endfunction

  function automatic logic [COUNTER_BITS-1:0] sat_add(logic [COUNTER_BITS-1:0] a,
                                                      logic [COUNTER_BITS-1:0] b);
    logic [COUNTER_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNTER_BITS] ? CMAX : s[COUNTER_BITS-1:0];
  endfunction

  // ------------------------------------------------------------------
  // configuration
  // ------------------------------------------------------------------
  logic cfg_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r <= 1'b0;
    end else if (cfg_we) begin
      cfg_en_r <= cfg_wdata;
    end
  end

  // ------------------------------------------------------------------
  // event register and step sequencer (issue stage)
  // ------------------------------------------------------------------
  logic        it_valid_r;
  logic        it_act_r;
  logic [2:0]  it_op_r;
  logic [2:0]  step_r;
  logic [31:0] it_size_r;
  logic [31:0] it_outcome_r;
  logic [7:0]  it_origin_r;
  logic        it_failed_r;
  logic        it_api32_r;
  logic [31:0] it_elapsed_r;
  logic        it_sub_r;
  logic [31:0] it_w_r;
  logic [31:0] it_h_r;
  logic [31:0] it_now_r;
  logic [5:0]  it_cidx_r;
  logic [31:0] it_px_r;

  logic        stall;
  logic        it_last;
  logic        a_fire;
  logic        in_take;
  uop_t        uop;

  // width and height clipped at zero, pixel count saturated to 32 bits
  logic [31:0] in_uw;
  logic [31:0] in_uh;
  logic [63:0] in_prod;
  logic        in_act;

  assign in_uw   = (in_bus.texture_width  > 32'sd0) ? 32'(in_bus.texture_width)  : '0;
  assign in_uh   = (in_bus.texture_height > 32'sd0) ? 32'(in_bus.texture_height) : '0;
  assign in_prod = {32'b0, in_uw} * {32'b0, in_uh};

  // update events only count while enabled; clear and readout always act
  assign in_act = ((in_bus.operation == OP_READ_DONE) || (in_bus.operation == OP_SEEK_DONE) ||
                   (in_bus.operation == OP_TEX_BEGIN) || (in_bus.operation == OP_TEX_END))
                  ? cfg_en_r
                  : ((in_bus.operation == OP_CLEAR) || (in_bus.operation == OP_READ_CNT));

  // next beat is taken while the last step of the current one issues
  assign in_bus.ready = !stall && (!it_valid_r || it_last);
  assign in_take      = in_bus.valid && in_bus.ready;
  assign a_fire       = it_valid_r && !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_valid_r <= 1'b0;
      step_r     <= '0;
    end else if (in_take) begin
      it_valid_r <= 1'b1;
      step_r     <= '0;
    end else if (a_fire) begin
      if (it_last) begin
        it_valid_r <= 1'b0;
      end
      step_r <= step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      it_act_r     <= in_act;
      it_op_r      <= in_bus.operation;
      it_size_r    <= in_bus.read_size;
      it_outcome_r <= 32'(in_bus.read_outcome);
      it_origin_r  <= in_bus.seek_origin;
      it_failed_r  <= in_bus.seek_failed;
      it_api32_r   <= in_bus.seek_api32;
      it_elapsed_r <= in_bus.elapsed_us;
      it_sub_r     <= in_bus.texture_sub;
      it_w_r       <= in_uw;
      it_h_r       <= in_uh;
      it_now_r     <= in_bus.now_us;
      it_cidx_r    <= in_bus.counter_index;
      it_px_r      <= (|in_prod[63:32]) ? '1 : in_prod[31:0];
    end
  end

  // step decoder: which counter each step touches and how
  logic [CNT_AW-1:0] lat_off;
  logic              idx_bad;

  assign lat_off = CNT_AW'(lat_bin(it_elapsed_r));
  assign idx_bad = (it_cidx_r >= 6'(NUM_COUNTERS));

  always_comb begin
    uop     = '{kind: U_NOP, addr: '0, amount: '0, bad_idx: 1'b0};
    it_last = 1'b1;
    if (it_act_r) begin
      unique case (it_op_r)
        OP_READ_DONE: begin
          it_last = (step_r == 3'd6);
          case (step_r)
            3'd0: uop = '{U_BUMP, C_RD_CALLS, 32'd1, 1'b0};
            3'd1: uop = '{U_BUMP, C_RD_REQ, it_size_r, 1'b0};
            3'd2: uop = '{U_BUMP, C_RD_TIME, it_elapsed_r, 1'b0};
            3'd3: uop = '{U_BUMP, C_RD_LAT + lat_off, 32'd1, 1'b0};
            3'd4: begin
              if (it_outcome_r[31]) uop = '{U_BUMP, C_RD_ERR, 32'd1, 1'b0};
              else                  uop = '{U_BUMP, C_RD_BYTES, it_outcome_r, 1'b0};
            end
            3'd5: begin
              if (!it_outcome_r[31]) uop = '{U_MAX, C_RD_MAX, it_outcome_r, 1'b0};
            end
            default: begin
              if (it_size_r <= SIZE_4K)       uop = '{U_BUMP, C_RD_LE4K, 32'd1, 1'b0};
              else if (it_size_r <= SIZE_64K) uop = '{U_BUMP, C_RD_LE64K, 32'd1, 1'b0};
              else                            uop = '{U_BUMP, C_RD_GT64K, 32'd1, 1'b0};
            end
          endcase
        end
        OP_SEEK_DONE: begin
          it_last = (step_r == 3'd5);
          case (step_r)
            3'd0: uop = '{U_BUMP, C_SK_CALLS, 32'd1, 1'b0};
            3'd1: uop = '{U_BUMP, it_api32_r ? C_SK_32 : C_SK_64, 32'd1, 1'b0};
            3'd2: begin
              if (it_origin_r == ORG_SET)      uop = '{U_BUMP, C_SK_SET, 32'd1, 1'b0};
              else if (it_origin_r == ORG_CUR) uop = '{U_BUMP, C_SK_CUR, 32'd1, 1'b0};
              else if (it_origin_r == ORG_END) uop = '{U_BUMP, C_SK_END, 32'd1, 1'b0};
              else                             uop = '{U_BUMP, C_SK_OTHER, 32'd1, 1'b0};
            end
            3'd3: uop = '{U_BUMP, C_SK_TIME, it_elapsed_r, 1'b0};
            3'd4: uop = '{U_BUMP, C_SK_LAT + lat_off, 32'd1, 1'b0};
            default: begin
              if (it_failed_r) uop = '{U_BUMP, C_SK_ERR, 32'd1, 1'b0};
            end
          endcase
        end
        OP_TEX_BEGIN: begin
          it_last = (step_r == 3'd7);
          case (step_r)
            3'd0: uop = '{U_BUMP, it_sub_r ? C_TX_SUB : C_TX_IMG, 32'd1, 1'b0};
            3'd1: begin
              if (it_px_r != '0) uop = '{U_BUMP, C_TX_PIX, it_px_r, 1'b0};
            end
            3'd2: begin
              if (it_px_r != '0) uop = '{U_MAX, C_TX_MAXPIX, it_px_r, 1'b0};
            end
            3'd3: uop = '{U_SET, C_TX_KIND, 32'(it_sub_r), 1'b0};
            3'd4: uop = '{U_SET, C_TX_W, it_w_r, 1'b0};
            3'd5: uop = '{U_SET, C_TX_H, it_h_r, 1'b0};
            3'd6: uop = '{U_SET, C_TX_BEGIN, it_now_r, 1'b0};
            default: uop = '{U_SET, C_TX_INFL, 32'd1, 1'b0};
          endcase
        end
        OP_TEX_END: begin
          it_last = (step_r == 3'd2);
          case (step_r)
            3'd0:    uop = '{U_INFL, C_TX_INFL, 32'd0, 1'b0};
            3'd1:    uop = '{U_BEGIN, C_TX_BEGIN, 32'd0, 1'b0};
            default: uop = '{U_TIME, C_TX_TIME, it_now_r, 1'b0};
          endcase
        end
        OP_CLEAR: uop = '{U_CLEAR, '0, 32'd0, 1'b0};
        OP_READ_CNT: begin
          uop = '{U_READ, idx_bad ? '0 : it_cidx_r[CNT_AW-1:0], 32'd0, idx_bad};
        end
        default: uop = '{U_NOP, '0, 32'd0, 1'b0};
      endcase
    end
  end

  // ------------------------------------------------------------------
  // counter ram
  // ------------------------------------------------------------------
  logic                    b_we;
  logic [CNT_AW-1:0]       b_waddr;
  logic [COUNTER_BITS-1:0] b_wdata;
  logic [COUNTER_BITS-1:0] ram_rdata;

  epc_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (NUM_COUNTERS)
  ) u_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (a_fire),
    .raddr (uop.addr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------
  // modify and write stage
  // ------------------------------------------------------------------
  logic                    b_valid_r;
  uop_t                    b_uop_r;
  logic [NUM_COUNTERS-1:0] cnt_vld_r;   // entry written since reset or clear
  logic                    fwd_valid_r; // write of the step just ahead
  logic [CNT_AW-1:0]       fwd_addr_r;
  logic [COUNTER_BITS-1:0] fwd_data_r;
  logic                    infl_r;      // texture in flight, seen by texture end
  logic [31:0]             begin_r;     // stored begin time, seen by texture end

  logic [COUNTER_BITS-1:0] cur;
  logic [COUNTER_BITS-1:0] amt_c;
  logic                    we_c;
  logic                    b_go;
  logic                    b_read;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (!stall) begin
      b_valid_r <= a_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      b_uop_r <= uop;
    end
  end

  // the ram returns the old word when the step ahead wrote the same entry
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == b_uop_r.addr)) begin
      cur = fwd_data_r;
    end else if (cnt_vld_r[b_uop_r.addr]) begin
      cur = ram_rdata;
    end else begin
      cur = '0;
    end
  end

  assign b_read = b_valid_r && (b_uop_r.kind == U_READ);
  assign stall  = b_read && out_bus.valid && !out_bus.ready;
  assign b_go   = b_valid_r && !stall;

  always_comb begin
    we_c    = 1'b0;
    b_wdata = cur;
    amt_c   = clamp_amt(b_uop_r.amount);
    case (b_uop_r.kind)
      U_BUMP: begin
        we_c    = 1'b1;
        b_wdata = sat_add(cur, amt_c);
      end
      U_MAX: begin
        we_c    = 1'b1;
        b_wdata = (amt_c > cur) ? amt_c : cur;
      end
      U_SET: begin
        we_c    = 1'b1;
        b_wdata = amt_c;
      end
      U_INFL: begin
        we_c    = 1'b1;
        b_wdata = '0;
      end
      U_TIME: begin
        // added time wraps at 32 bits
        amt_c   = clamp_amt(b_uop_r.amount - begin_r);
        we_c    = infl_r;
        b_wdata = sat_add(cur, amt_c);
      end
      default: begin
        we_c = 1'b0;
      end
    endcase
  end

  assign b_we    = b_go && we_c;
  assign b_waddr = b_uop_r.addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r   <= '0;
      fwd_valid_r <= 1'b0;
    end else if (!stall) begin
      fwd_valid_r <= b_we;
      if (b_go && (b_uop_r.kind == U_CLEAR)) begin
        cnt_vld_r <= '0;
      end else if (b_we) begin
        cnt_vld_r[b_uop_r.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      fwd_addr_r <= b_waddr;
      fwd_data_r <= b_wdata;
    end
    if (b_go && (b_uop_r.kind == U_INFL)) begin
      infl_r <= (cur != '0);
    end
    if (b_go && (b_uop_r.kind == U_BEGIN)) begin
      begin_r <= 32'(cur);
    end
  end

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic        out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_read && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_read && !stall) begin
      out_value_r <= b_uop_r.bad_idx ? '0 : 32'(cur);
      out_bad_r   <= b_uop_r.bad_idx;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.counter_value = out_value_r;
  assign out_bus.index_invalid = out_bad_r;

endmodule

// ----- rtl/epc_checker.sv -----
// port-level checks on the profile counters, bound to the top level
module epc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] counter_value,
  input logic        index_invalid
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(counter_value) && $stable(index_invalid))
    else $error("result beat dropped or changed while stalled");

  // an index beyond the counter map reads as zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && index_invalid |-> counter_value == 32'd0)
    else $error("invalid index with nonzero value");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind io_event_profile_counters_core epc_checker u_epc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .counter_value (out_bus.counter_value),
  .index_invalid (out_bus.index_invalid)
);
